// File: rtl/arpbsc_pkg.sv
// Shared types and constants for the ARP sender binding check.
`default_nettype none

package arpbsc_pkg;

  localparam int TABLE_ENTRIES_DEFAULT = 64;

  localparam int ETYPE_W = 16;
  localparam int IP_W    = 32;
  localparam int MAC_W   = 48;
  localparam int SLOT_W  = 6;
  localparam int ENTRY_W = IP_W + MAC_W;

  localparam logic [ETYPE_W-1:0] ARP_ETHERTYPE_RESET = 16'h0806;

  // Register map: byte address bit 2 selects the register word.
  localparam int  PADDR_W            = 3;
  localparam logic REG_IDX_ETHERTYPE = 1'b0;

  typedef enum logic [2:0] {
    VERDICT_NOT_ARP    = 3'd0,
    VERDICT_LEARNED    = 3'd1,
    VERDICT_CONSISTENT = 3'd2,
    VERDICT_SPOOF      = 3'd3,
    VERDICT_FULL       = 3'd4
  } verdict_t;

  typedef struct packed {
    logic     load;
    logic     scan_clear;
    logic     scan_step;
    logic     write_learn;
    logic     write_spoof;
    logic     emit;
    verdict_t verdict_code;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_arp;
    logic hit;
    logic mac_same;
    logic scan_end;
    logic full;
  } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/arpbsc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module arpbsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/arpbsc_ctrl.sv
// Sequencing state machine for the binding check.
`default_nettype none

module arpbsc_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire arpbsc_pkg::dp_status_t status,
  output arpbsc_pkg::ctrl_cmd_t       cmd,
  output logic                        busy,
  output logic                        done
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN
  } state_t;

  state_t state;
  state_t state_next;
  logic   done_next;

  always_comb begin
    state_next       = state;
    done_next        = 1'b0;
    cmd.load         = 1'b0;
    cmd.scan_clear   = 1'b0;
    cmd.scan_step    = 1'b0;
    cmd.write_learn  = 1'b0;
    cmd.write_spoof  = 1'b0;
    cmd.emit         = 1'b0;
    cmd.verdict_code = arpbsc_pkg::VERDICT_NOT_ARP;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!status.is_arp) begin
          cmd.emit         = 1'b1;
          cmd.verdict_code = arpbsc_pkg::VERDICT_NOT_ARP;
          done_next        = 1'b1;
          state_next       = ST_IDLE;
        end else begin
          cmd.scan_clear = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.hit) begin
          cmd.emit   = 1'b1;
          done_next  = 1'b1;
          state_next = ST_IDLE;
          if (status.mac_same) begin
            cmd.verdict_code = arpbsc_pkg::VERDICT_CONSISTENT;
          end else begin
            cmd.write_spoof  = 1'b1;
            cmd.verdict_code = arpbsc_pkg::VERDICT_SPOOF;
          end
        end else if (status.scan_end) begin
          cmd.emit   = 1'b1;
          done_next  = 1'b1;
          state_next = ST_IDLE;
          if (status.full) begin
            cmd.verdict_code = arpbsc_pkg::VERDICT_FULL;
          end else begin
            cmd.write_learn  = 1'b1;
            cmd.verdict_code = arpbsc_pkg::VERDICT_LEARNED;
          end
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

`default_nettype wire

// File: rtl/arpbsc_dp.sv
// Datapath: input capture, binding table, scan pointer and result registers.
`default_nettype none

module arpbsc_dp #(
  parameter int TABLE_ENTRIES = arpbsc_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire arpbsc_pkg::ctrl_cmd_t             cmd,
  input  wire logic [arpbsc_pkg::ETYPE_W-1:0]    arp_ethertype,
  input  wire logic [arpbsc_pkg::ETYPE_W-1:0]    frame_ethertype,
  input  wire logic [arpbsc_pkg::IP_W-1:0]       sender_ip,
  input  wire logic [arpbsc_pkg::MAC_W-1:0]      sender_mac,
  output arpbsc_pkg::dp_status_t                 status,
  output logic      [2:0]                        verdict,
  output logic      [arpbsc_pkg::MAC_W-1:0]      previous_mac,
  output logic      [arpbsc_pkg::SLOT_W-1:0]     slot_index
);

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);

  logic [arpbsc_pkg::ETYPE_W-1:0] etype_q;
  logic [arpbsc_pkg::IP_W-1:0]    ip_q;
  logic [arpbsc_pkg::MAC_W-1:0]   mac_q;

  // Entries are filled lowest first and never freed, so the valid entries
  // are exactly those below the fill count.
  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] rd_ptr;
  logic             rd_pending;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] res_idx;

  logic                             ram_we;
  logic [IDX_W-1:0]                 ram_waddr;
  logic                             ram_re;
  logic [arpbsc_pkg::ENTRY_W-1:0]   ram_rdata;
  logic [arpbsc_pkg::IP_W-1:0]      rd_ip;
  logic [arpbsc_pkg::MAC_W-1:0]     rd_mac;
  logic                             ptr_in_range;

  assign rd_ip  = ram_rdata[arpbsc_pkg::ENTRY_W-1:arpbsc_pkg::MAC_W];
  assign rd_mac = ram_rdata[arpbsc_pkg::MAC_W-1:0];

  assign ptr_in_range = (rd_ptr < used);
  assign ram_re       = cmd.scan_step && ptr_in_range;
  assign ram_we       = cmd.write_learn || cmd.write_spoof;
  assign ram_waddr    = cmd.write_spoof ? rd_idx : used[IDX_W-1:0];

  arpbsc_ram #(
    .WIDTH (arpbsc_pkg::ENTRY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata ({ip_q, mac_q}),
    .re    (ram_re),
    .raddr (rd_ptr[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign status.is_arp   = (etype_q == arp_ethertype);
  assign status.hit      = rd_pending && (rd_ip == ip_q);
  assign status.mac_same = (rd_mac == mac_q);
  assign status.scan_end = !rd_pending && !ptr_in_range;
  assign status.full     = (used == CNT_FULL);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      etype_q <= frame_ethertype;
      ip_q    <= sender_ip;
      mac_q   <= sender_mac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      rd_ptr     <= '0;
      rd_pending <= 1'b0;
    end else begin
      if (cmd.write_learn) begin
        used <= used + CNT_W'(1);
      end
      if (cmd.scan_clear) begin
        rd_ptr     <= '0;
        rd_pending <= 1'b0;
      end else if (cmd.scan_step) begin
        rd_pending <= ptr_in_range;
        if (ptr_in_range) begin
          rd_ptr <= rd_ptr + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_idx <= rd_ptr[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      verdict <= cmd.verdict_code;
      case (cmd.verdict_code) inside
        arpbsc_pkg::VERDICT_CONSISTENT, arpbsc_pkg::VERDICT_SPOOF: begin
          previous_mac <= rd_mac;
          res_idx      <= rd_idx;
        end
        arpbsc_pkg::VERDICT_LEARNED: begin
          previous_mac <= '0;
          res_idx      <= used[IDX_W-1:0];
        end
        default: begin
          previous_mac <= '0;
          res_idx      <= '0;
        end
      endcase
    end
  end

  assign slot_index = arpbsc_pkg::SLOT_W'(res_idx);

endmodule

`default_nettype wire

// File: rtl/arp_binding_spoof_check.sv
// Top level of the ARP sender IP-to-MAC binding check with its register port.
// A frame whose EtherType is not ARP gives its word without scanning the table.
// An ARP frame scans the valid entries one per cycle from the table RAM, stopping at
// the first entry whose IP matches or after the last of the used learned entries.
// busy stays high for the whole scan; the next start is taken in the cycle done shows.
// Reset clears the fill count and the controller; table contents need no clearing.
`default_nettype none

module arp_binding_spoof_check #(
  parameter int TABLE_ENTRIES = arpbsc_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Command side: a frame is taken when start is high and busy is low.
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [arpbsc_pkg::ETYPE_W-1:0]    frame_ethertype,
  input  wire logic [arpbsc_pkg::IP_W-1:0]       sender_ip,
  input  wire logic [arpbsc_pkg::MAC_W-1:0]      sender_mac,
  // Result side: each word is valid for the single cycle in which done is high.
  output logic                                   done,
  output logic      [2:0]                        verdict,
  output logic      [arpbsc_pkg::MAC_W-1:0]      previous_mac,
  output logic      [arpbsc_pkg::SLOT_W-1:0]     slot_index,
  // APB register port.
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [arpbsc_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready
);

  arpbsc_pkg::ctrl_cmd_t  cmd;
  arpbsc_pkg::dp_status_t status;

  // The only register is the EtherType that marks a frame as ARP. Byte
  // address bit 2 selects the register word; the low bits are the byte lane
  // offset and are ignored, so any write to the second word is dropped.
  logic [arpbsc_pkg::ETYPE_W-1:0] arp_ethertype;
  logic                           reg_write;
  logic                           sel_ethertype;

  assign pready        = 1'b1;
  assign sel_ethertype = (paddr[2] == arpbsc_pkg::REG_IDX_ETHERTYPE);
  assign reg_write     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      arp_ethertype <= arpbsc_pkg::ARP_ETHERTYPE_RESET;
    end else if (reg_write && sel_ethertype) begin
      arp_ethertype <= pwdata[arpbsc_pkg::ETYPE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (sel_ethertype) begin
      prdata = 32'(arp_ethertype);
    end
  end

  // The controller sequences capture, the table scan and any table write at the end;
  // the datapath holds the table RAM, the fill count and the result word.
  arpbsc_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  arpbsc_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .arp_ethertype   (arp_ethertype),
    .frame_ethertype (frame_ethertype),
    .sender_ip       (sender_ip),
    .sender_mac      (sender_mac),
    .status          (status),
    .verdict         (verdict),
    .previous_mac    (previous_mac),
    .slot_index      (slot_index)
  );

endmodule

`default_nettype wire

// File: rtl/arpbsc_checker.sv
// Port-level checker for the binding check, bound to the top level.
`default_nettype none

module arpbsc_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           start,
  input wire logic                           busy,
  input wire logic                           done,
  input wire logic [2:0]                     verdict,
  input wire logic [arpbsc_pkg::MAC_W-1:0]   previous_mac,
  input wire logic [arpbsc_pkg::SLOT_W-1:0]  slot_index,
  input wire logic                           pready
);

  // A word is only shown once the block has gone back to idle.
  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result word shown while busy");

  // An accepted frame always makes the block busy before any word is shown.
  a_accept_busy : assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("accepted frame did not make the block busy");

  a_verdict_range : assert property (@(posedge clk) disable iff (rst)
    done |-> verdict <= 3'(arpbsc_pkg::VERDICT_FULL))
    else $error("verdict code out of range");

  a_no_binding_zero : assert property (@(posedge clk) disable iff (rst)
    done && (verdict == 3'(arpbsc_pkg::VERDICT_NOT_ARP) ||
             verdict == 3'(arpbsc_pkg::VERDICT_FULL))
      |-> previous_mac == '0 && slot_index == '0)
    else $error("nonzero binding fields without a binding");

  a_pready : assert property (@(posedge clk) disable iff (rst)
    pready)
    else $error("register port stalled");

endmodule

bind arp_binding_spoof_check arpbsc_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .verdict      (verdict),
  .previous_mac (previous_mac),
  .slot_index   (slot_index),
  .pready       (pready)
);

`default_nettype wire
